// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the filter bank RTL files.
// Each macro expects a clock named clk and an active-low reset named arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define SFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SFB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared widths, register codes, FIR coefficient table, helper functions and
// types of the sample filter bank.
// ----------------------------------------------------------------------------
package sfb_pkg;

	// field widths
	localparam int SAMPLE_W   = 16;
	localparam int OUT_W      = 24;
	localparam int FRAC_W     = 8;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 15;
	localparam int AVG_LEN_W  = 7;

	// arithmetic widths
	localparam int COEF_W     = 13;
	localparam int COEF_COUNT = 26;
	localparam int MUL_A_W    = GAIN_W + 1;
	localparam int PROD_W     = MUL_A_W + OUT_W;
	localparam int FIR_ACC_W  = 34;
	localparam int IIR_ACC_W  = 42;
	localparam int FIR_HALF   = 1 << (FRAC_W - 1);
	localparam int IIR_HALF   = 1 << (GAIN_FRAC - 1);

	localparam int OUT_MAX    = 8388607;
	localparam int OUT_MIN    = -8388608;

	// configuration port
	localparam int PADDR_W    = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_AVG_LEN       = 2'd0;
	localparam logic [1:0] REG_FEED_GAIN     = 2'd1;
	localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd2;

	localparam logic [AVG_LEN_W-1:0] AVG_LEN_RESET       = 7'd50;
	localparam logic [GAIN_W-1:0]    FEED_GAIN_RESET     = 16'd3277;
	localparam logic [GAIN_W-1:0]    FEEDBACK_GAIN_RESET = 16'd29491;

	// symmetric low-pass taps, unsigned Q0.16
	localparam logic [COEF_W-1:0] FIR_COEF [COEF_COUNT] = '{
		13'd201,  13'd272,  13'd443,  13'd732,  13'd1144, 13'd1670, 13'd2284,
		13'd2950, 13'd3618, 13'd4238, 13'd4757, 13'd5131, 13'd5327, 13'd5327,
		13'd5131, 13'd4757, 13'd4238, 13'd3618, 13'd2950, 13'd2284, 13'd1670,
		13'd1144, 13'd732,  13'd443,  13'd272,  13'd201
	};

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_IIR_B,
		ST_IIR_A,
		ST_IIR_SUM,
		ST_DIVIDE,
		ST_FINISH
	} sfb_state_t;

	// operand select of the shared multiplier
	typedef enum logic [1:0] {
		MUL_TAP,
		MUL_FEEDBACK,
		MUL_FEED
	} sfb_mul_sel_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} sfb_div_status_t;

	// coefficient of tap k, zero past the table
	function automatic logic [COEF_W-1:0] fir_coef(input logic [7:0] k);
		if (k < 8'(COEF_COUNT)) begin
			return FIR_COEF[k[4:0]];
		end
		return '0;
	endfunction

	// clamp a wide signed value to the 24-bit result range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [IIR_ACC_W-1:0] v);
		if (v > IIR_ACC_W'(OUT_MAX)) begin
			return OUT_W'(OUT_MAX);
		end
		if (v < IIR_ACC_W'(OUT_MIN)) begin
			return OUT_W'(OUT_MIN);
		end
		return v[OUT_W-1:0];
	endfunction

endpackage

// File: hw/rtl/sample_filter_bank.sv
// ----------------------------------------------------------------------------
// sample_filter_bank
// Moving average, 25-tap low-pass FIR and first-order IIR over a stream of
// signed 16-bit samples, one result transfer per sample transfer.
//
// Each accepted sample is written into a circular history memory and the
// block then stays busy (s_tready low) until its result is registered. The
// history is swept newest first at one entry per cycle through the memory
// read port, L = max(N, min(FIR_TAPS, 26, HISTORY_DEPTH)) entries, where N is
// average_length clamped to 1..HISTORY_DEPTH; each of the newest N entries is
// added into the average sum, and each entry within the FIR taps is
// multiplied by its tap in the one shared 17x24 multiplier. The same
// multiplier then forms the two IIR products, and a one-bit-per-cycle divider
// produces the rounded mean. A finished result waits in the output register
// while the next sample is taken. History entries that were never written
// read as zero through a fill count, so no clearing pass follows reset.
// Registers sit at byte addresses 0 (average_length), 4 (feed_gain) and 8
// (feedback_gain), and are to be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_filter_bank #(
	parameter int HISTORY_DEPTH = 64,
	parameter int FIR_TAPS      = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfb_pkg::PADDR_W-1:0]     paddr,
	input  logic [sfb_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sfb_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// sample stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,  // [15:0] sample
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [71:0]                     m_tdata   // [23:0] average, [47:24] fir_result,
	                                                  // [71:48] iir_result
);
	import sfb_pkg::*;

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int NW  = $clog2(HISTORY_DEPTH + 1);
	localparam int AVW = SAMPLE_W + AW;
	localparam int DW  = AVW + FRAC_W;
	localparam int FIR_T1  = (FIR_TAPS < COEF_COUNT) ? FIR_TAPS : COEF_COUNT;
	localparam int FIR_EFF = (FIR_T1 < HISTORY_DEPTH) ? FIR_T1 : HISTORY_DEPTH;

	// sequencer
	sfb_state_t   state_q;
	sfb_state_t   state_d;
	logic         s_ready_c;
	logic         issue;
	logic         div_start;
	logic         out_load;
	sfb_mul_sel_t mul_sel;

	// configuration
	logic [AVG_LEN_W-1:0] avg_len_q;
	logic [GAIN_W-1:0]    feed_gain_q;
	logic [GAIN_W-1:0]    feedback_gain_q;
	logic                 cfg_we;

	// history and sweep control
	logic [SAMPLE_W-1:0]  hist_mem [HISTORY_DEPTH];
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        wp_next;
	logic [NW-1:0]        fill_q;
	logic [AW-1:0]        rd_addr_q;
	logic [NW-1:0]        k_q;
	logic [NW-1:0]        n_q;
	logic [NW-1:0]        n_new;
	logic [NW-1:0]        sweep_len_q;
	logic [NW-1:0]        sweep_new;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                 accept_in;

	// sweep pipeline
	logic [SAMPLE_W-1:0]        rdata_s1;
	logic [NW-1:0]              k_s1;
	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] hist_m;
	logic signed [SAMPLE_W-1:0] h_s2;
	logic                       ae_s2;
	logic                       fe_s2;
	logic                       v_s2;
	logic signed [PROD_W-1:0]   prod_s2;

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [OUT_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	// accumulators and state
	logic signed [AVW-1:0]       avg_acc_q;
	logic signed [FIR_ACC_W-1:0] fir_acc_q;
	logic signed [IIR_ACC_W-1:0] iir_acc_q;
	logic signed [OUT_W-1:0]     iir_prev_q;

	// divider and result shaping
	logic [AVW-1:0]              avg_abs;
	logic [DW-1:0]               dividend;
	logic [OUT_W-1:0]            div_quot;
	sfb_div_status_t             div_st;
	logic signed [OUT_W:0]       avg_mag;
	logic signed [OUT_W:0]       avg_full;
	logic signed [FIR_ACC_W-1:0] fir_bias;
	logic signed [FIR_ACC_W-1:0] fir_shift;
	logic signed [IIR_ACC_W-1:0] iir_bias;
	logic signed [IIR_ACC_W-1:0] iir_shift;
	logic signed [OUT_W-1:0]     avg_sat;
	logic signed [OUT_W-1:0]     fir_sat;
	logic signed [OUT_W-1:0]     iir_sat;

	// output register
	logic                    m_tvalid_q;
	logic signed [OUT_W-1:0] out_avg_q;
	logic signed [OUT_W-1:0] out_fir_q;
	logic signed [OUT_W-1:0] out_iir_q;

	assign accept_in = s_tvalid && s_ready_c;
	assign cfg_we    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	// next write slot and clamped lengths
	always_comb begin
		wp_next = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
		if (avg_len_q == '0) begin
			n_new = NW'(1);
		end else if (int'(avg_len_q) > HISTORY_DEPTH) begin
			n_new = NW'(HISTORY_DEPTH);
		end else begin
			n_new = NW'(avg_len_q);
		end
		sweep_new = (n_new > NW'(FIR_EFF)) ? n_new : NW'(FIR_EFF);
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_AVG_LEN:       prdata = APB_DATA_W'(avg_len_q);
			REG_FEED_GAIN:     prdata = APB_DATA_W'(feed_gain_q);
			REG_FEEDBACK_GAIN: prdata = APB_DATA_W'(feedback_gain_q);
			default:           prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_SWEEP;
			ST_SWEEP:   if (k_q == sweep_len_q - NW'(1)) state_d = ST_DRAIN;
			ST_DRAIN:   if (!v_s1) state_d = ST_IIR_B;
			ST_IIR_B:   state_d = ST_IIR_A;
			ST_IIR_A:   state_d = ST_IIR_SUM;
			ST_IIR_SUM: state_d = ST_DIVIDE;
			ST_DIVIDE:  if (div_st.done) state_d = ST_FINISH;
			ST_FINISH:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_ready_c = 1'b0;
		issue     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_sel   = MUL_TAP;
		unique case (state_q)
			ST_IDLE:    s_ready_c = 1'b1;
			ST_SWEEP:   issue = 1'b1;
			ST_DRAIN:   mul_sel = MUL_TAP;
			ST_IIR_B:   mul_sel = MUL_FEEDBACK;
			ST_IIR_A:   mul_sel = MUL_FEED;
			ST_IIR_SUM: div_start = 1'b1;
			ST_DIVIDE:  mul_sel = MUL_TAP;
			ST_FINISH:  out_load = !m_tvalid_q || m_tready;
			default:    s_ready_c = 1'b0;
		endcase
	end

	// history memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept_in) begin
			hist_mem[wp_next] <= s_tdata;
		end
		rdata_s1 <= hist_mem[rd_addr_q];
	end

	// entries older than the fill count read as zero
	assign hist_m = (k_s1 < fill_q) ? signed'(rdata_s1) : '0;

	// shared multiplier operand select
	always_comb begin
		unique case (mul_sel)
			MUL_FEEDBACK: begin
				mul_a = signed'({1'b0, feedback_gain_q});
				mul_b = iir_prev_q;
			end
			MUL_FEED: begin
				mul_a = signed'({1'b0, feed_gain_q});
				mul_b = signed'({sample_q, {FRAC_W{1'b0}}});
			end
			default: begin
				mul_a = signed'({{(MUL_A_W - COEF_W){1'b0}}, fir_coef(8'(k_s1))});
				mul_b = OUT_W'(hist_m);
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			avg_len_q       <= AVG_LEN_RESET;
			feed_gain_q     <= FEED_GAIN_RESET;
			feedback_gain_q <= FEEDBACK_GAIN_RESET;
			wp_q            <= '0;
			fill_q          <= '0;
			k_q             <= '0;
			sweep_len_q     <= NW'(1);
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			m_tvalid_q      <= 1'b0;
			iir_prev_q      <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (cfg_we) begin
				unique case (paddr[3:2])
					REG_AVG_LEN:       avg_len_q       <= pwdata[AVG_LEN_W-1:0];
					REG_FEED_GAIN:     feed_gain_q     <= pwdata[GAIN_W-1:0];
					REG_FEEDBACK_GAIN: feedback_gain_q <= pwdata[GAIN_W-1:0];
					default:           avg_len_q       <= avg_len_q;
				endcase
			end
			if (accept_in) begin
				wp_q        <= wp_next;
				k_q         <= '0;
				sweep_len_q <= sweep_new;
				if (fill_q != NW'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + NW'(1);
				end
			end else if (issue) begin
				k_q <= k_q + NW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				iir_prev_q <= iir_sat;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// sweep pipeline and accumulators
	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		h_s2    <= hist_m;
		ae_s2   <= (k_s1 < n_q);
		fe_s2   <= (k_s1 < NW'(FIR_EFF));
		prod_s2 <= mul_p;
		if (accept_in) begin
			rd_addr_q <= wp_next;
			n_q       <= n_new;
			sample_q  <= signed'(s_tdata);
			avg_acc_q <= '0;
			fir_acc_q <= '0;
		end else begin
			if (issue) begin
				rd_addr_q <= (rd_addr_q == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_q - AW'(1);
			end
			if (v_s2 && ae_s2) begin
				avg_acc_q <= avg_acc_q + AVW'(h_s2);
			end
			if (v_s2 && fe_s2) begin
				fir_acc_q <= fir_acc_q + FIR_ACC_W'(prod_s2);
			end
		end
		if (state_q == ST_IIR_A) begin
			iir_acc_q <= IIR_ACC_W'(prod_s2);
		end else if (state_q == ST_IIR_SUM) begin
			iir_acc_q <= iir_acc_q + IIR_ACC_W'(prod_s2);
		end
	end

	// rounded mean: (|sum| * 256 + n/2) / n
	always_comb begin
		avg_abs  = avg_acc_q[AVW-1] ? unsigned'(-avg_acc_q) : unsigned'(avg_acc_q);
		dividend = {avg_abs, {FRAC_W{1'b0}}} + DW'(n_q >> 1);
	end

	sfb_divider #(
		.DIVIDEND_W (DW),
		.DIVISOR_W  (NW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.quotient (div_quot),
		.status   (div_st)
	);

	// sign restore, round half away from zero, saturate
	always_comb begin
		avg_mag   = signed'({1'b0, div_quot});
		avg_full  = avg_acc_q[AVW-1] ? -avg_mag : avg_mag;
		avg_sat   = sat_out(IIR_ACC_W'(avg_full));
		fir_bias  = fir_acc_q + (fir_acc_q[FIR_ACC_W-1] ? FIR_ACC_W'(FIR_HALF - 1)
		                                                : FIR_ACC_W'(FIR_HALF));
		fir_shift = fir_bias >>> FRAC_W;
		fir_sat   = sat_out(IIR_ACC_W'(fir_shift));
		iir_bias  = iir_acc_q + (iir_acc_q[IIR_ACC_W-1] ? IIR_ACC_W'(IIR_HALF - 1)
		                                                : IIR_ACC_W'(IIR_HALF));
		iir_shift = iir_bias >>> GAIN_FRAC;
		iir_sat   = sat_out(iir_shift);
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_avg_q <= avg_sat;
			out_fir_q <= fir_sat;
			out_iir_q <= iir_sat;
		end
	end

	assign s_tready = s_ready_c;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_iir_q, out_fir_q, out_avg_q};

	`SFB_ASSERT(a_fill_bound, fill_q <= NW'(HISTORY_DEPTH), "fill count past history depth")
	`SFB_ASSERT(a_sweep_bound, k_q <= sweep_len_q, "sweep index past sweep length")
	`SFB_ASSERT_IMPLY(a_done_in_divide, div_st.done, state_q == ST_DIVIDE, "divider done outside divide")
	`SFB_ASSERT_NEXT(a_result_held, state_q == ST_FINISH && m_tvalid_q && !m_tready,
		state_q == ST_FINISH, "pending result overwritten")

endmodule

// File: hw/rtl/sfb_divider.sv
// ----------------------------------------------------------------------------
// sfb_divider
// Restoring unsigned divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in OUT_W bits, so only the low OUT_W
// dividend bits are iterated and the upper bits seed the remainder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfb_divider #(
	parameter int DIVIDEND_W = 30,
	parameter int DIVISOR_W  = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_W-1:0]    dividend,
	input  logic [DIVISOR_W-1:0]     divisor,
	output logic [sfb_pkg::OUT_W-1:0] quotient,
	output sfb_pkg::sfb_div_status_t status
);
	import sfb_pkg::*;

	localparam int CW = $clog2(OUT_W);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [OUT_W-1:0]     quo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVIDEND_W-1:0] dividend_hi;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// upper dividend bits start the remainder
	assign dividend_hi = dividend >> OUT_W;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[OUT_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(OUT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi[DIVISOR_W-1:0];
			quo_q <= dividend[OUT_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[OUT_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	`SFB_ASSERT_IMPLY(a_div_rem_below, busy_q, rem_q < dvs_q, "divider remainder not below divisor")
	`SFB_ASSERT_IMPLY(a_div_start_idle, start, !busy_q, "divider restarted while busy")
	`SFB_ASSERT_IMPLY(a_div_done_end, done_q, !busy_q && $past(busy_q), "divider done without a run")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sample filter bank: a directed table of samples
// and register writes, then randomized phases with varied gains, averaging
// lengths and back-pressure. Every result transfer is compared field by field
// against a typed row result or a model of the moving average, FIR and IIR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import sfb_pkg::*;

	localparam int HIST_DEPTH   = 64;
	localparam int TAP_COUNT    = 25;
	localparam int HOLD_CYCLES  = 500;
	localparam int PHASE_ITEMS  = 192;
	localparam int PHASE_COUNT  = 10;
	localparam logic [1:0] REG_SPARE = 2'd3;

	// low-pass weights of the first 25 taps, unsigned Q0.16
	localparam int TAP_WEIGHT [TAP_COUNT] = '{
		201, 272, 443, 732, 1144, 1670, 2284, 2950, 3618, 4238, 4757, 5131, 5327,
		5327, 5131, 4757, 4238, 3618, 2950, 2284, 1670, 1144, 732, 443, 272
	};

	typedef struct packed {
		logic [23:0] iir;
		logic [23:0] fir;
		logic [23:0] average;
	} filter_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic [1:0]     reg_idx;
		logic [31:0]    value;
		logic [15:0]    sample;
		logic           typed;
		filter_result_t typed_result;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [15:0] sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // [23:0] average, [47:24] fir_result, [71:48] iir_result

	// model state and register copies
	logic signed [15:0] sample_history [HIST_DEPTH];
	logic signed [23:0] iir_state;
	logic [6:0]         avg_len_reg;
	logic [15:0]        feed_gain_reg;
	logic [15:0]        feedback_gain_reg;

	filter_result_t expected_results [$];
	stim_row_t      directed_rows [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_trigger  = 0;
	int hold_taken    = 0;
	int hold_left     = 0;
	int mismatch_count = 0;
	int run_left      = 0;
	logic [15:0] run_value   = '0;
	logic [15:0] last_sample = '0;

	sample_filter_bank #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.FIR_TAPS     (TAP_COUNT)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #6 clk = ~clk;

	// round to nearest, ties away from zero
	function automatic longint round_half_away(input longint v, input int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -((-v + half) >>> s);
	endfunction

	function automatic logic [23:0] clamp_q16_8(input longint v);
		if (v > 64'sd8388607) begin
			return 24'h7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'h800000;
		end
		return v[23:0];
	endfunction

	// shift in one sample and compute the three filter outputs
	function automatic filter_result_t filter_sample(input logic [15:0] raw);
		filter_result_t res;
		longint acc;
		longint mag;
		longint n;
		for (int k = HIST_DEPTH - 1; k > 0; k--) begin
			sample_history[k] = sample_history[k-1];
		end
		sample_history[0] = $signed(raw);

		// moving average, length clamped to 1..depth
		n = longint'(avg_len_reg);
		if (n == 0) begin
			n = 1;
		end
		if (n > HIST_DEPTH) begin
			n = HIST_DEPTH;
		end
		acc = 0;
		for (int k = 0; k < n; k++) begin
			acc += longint'(sample_history[k]);
		end
		acc = acc * 256;
		mag = (acc < 0) ? -acc : acc;
		mag = (mag + n / 2) / n;
		res.average = clamp_q16_8((acc < 0) ? -mag : mag);

		// low-pass fir
		acc = 0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			acc += longint'(TAP_WEIGHT[k]) * longint'(sample_history[k]);
		end
		res.fir = clamp_q16_8(round_half_away(acc, 8));

		// first-order iir, state follows every sample
		acc = longint'(feedback_gain_reg) * longint'(iir_state)
			+ longint'(feed_gain_reg) * (longint'($signed(raw)) * 256);
		res.iir = clamp_q16_8(round_half_away(acc, 15));
		iir_state = res.iir;
		return res;
	endfunction

	function automatic stim_row_t sample_row(input logic [15:0] v);
		return '{kind: ROW_SAMPLE, reg_idx: REG_AVG_LEN, value: '0, sample: v,
			typed: 1'b0, typed_result: '0};
	endfunction

	function automatic stim_row_t typed_row(input logic [15:0] v, input logic [23:0] avg,
			input logic [23:0] fir, input logic [23:0] iir);
		return '{kind: ROW_SAMPLE, reg_idx: REG_AVG_LEN, value: '0, sample: v,
			typed: 1'b1, typed_result: '{iir: iir, fir: fir, average: avg}};
	endfunction

	function automatic stim_row_t write_row(input logic [1:0] idx, input logic [31:0] v);
		return '{kind: ROW_WRITE, reg_idx: idx, value: v, sample: '0,
			typed: 1'b0, typed_result: '0};
	endfunction

	// random sample: full range, extremes, small values, runs and slow drifts
	function automatic logic [15:0] pick_sample();
		int r;
		logic [15:0] v;
		if (run_left > 0) begin
			run_left--;
			last_sample = run_value;
			return run_value;
		end
		r = $urandom_range(15);
		if (r < 6) begin
			v = 16'($urandom());
		end else if (r == 6) begin
			v = 16'h7FFF;
		end else if (r == 7) begin
			v = 16'h8000;
		end else if (r < 10) begin
			v = 16'($urandom_range(64)) - 16'd32;
		end else if (r < 12) begin
			case ($urandom_range(2))
				0: run_value = 16'h7FFF;
				1: run_value = 16'h8000;
				default: run_value = 16'($urandom());
			endcase
			run_left = $urandom_range(70, 4);
			v = run_value;
		end else begin
			v = last_sample + 16'($urandom_range(512)) - 16'd256;
		end
		last_sample = v;
		return v;
	endfunction

	function automatic logic [31:0] pick_length();
		int r;
		r = $urandom_range(9);
		if (r < 4) begin
			return $urandom_range(8, 1);
		end
		if (r < 7) begin
			return $urandom_range(127);
		end
		if (r == 7) begin
			return 64;
		end
		return (r == 8) ? 1 : 0;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(6))
			0: return 0;
			1: return 32768;
			2: return 65535;
			3: return $urandom_range(65535);
			default: return $urandom_range(32768);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatch_count < 10) begin
			$display("mismatch on %s: expected %h, got %h", what, want, got);
		end
		mismatch_count++;
	endtask

	// apb write then read back of one register
	task automatic write_register(input logic [1:0] idx, input logic [31:0] v);
		logic [31:0] want;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_AVG_LEN:       avg_len_reg       = v[6:0];
			REG_FEED_GAIN:     feed_gain_reg     = v[15:0];
			REG_FEEDBACK_GAIN: feedback_gain_reg = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx != REG_SPARE) begin
			case (idx)
				REG_AVG_LEN:   want = {25'd0, avg_len_reg};
				REG_FEED_GAIN: want = {16'd0, feed_gain_reg};
				default:       want = {16'd0, feedback_gain_reg};
			endcase
			if (prdata != want) begin
				note_mismatch("register readback", want, prdata);
			end
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// offer one sample, queue its expected result once transferred
	task automatic send_sample(input logic [15:0] v, input logic typed,
			input filter_result_t typed_result);
		filter_result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = filter_sample(v);
		expected_results.push_back(typed ? typed_result : predicted);
	endtask

	// stop offering and let every pending result come out
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// result side ready, with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_trigger != hold_taken) begin
			hold_taken = hold_trigger;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		filter_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("result transfer with nothing expected: %h", m_tdata);
				end
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[23:0] != want.average) begin
					note_mismatch("average", {8'd0, want.average}, {8'd0, m_tdata[23:0]});
				end
				if (m_tdata[47:24] != want.fir) begin
					note_mismatch("fir_result", {8'd0, want.fir}, {8'd0, m_tdata[47:24]});
				end
				if (m_tdata[71:48] != want.iir) begin
					note_mismatch("iir_result", {8'd0, want.iir}, {8'd0, m_tdata[71:48]});
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < HIST_DEPTH; k++) begin
			sample_history[k] = '0;
		end
		iir_state         = '0;
		avg_len_reg       = AVG_LEN_RESET;
		feed_gain_reg     = FEED_GAIN_RESET;
		feedback_gain_reg = FEEDBACK_GAIN_RESET;

		directed_rows = '{
			typed_row(16'h0000, 24'h000000, 24'h000000, 24'h000000),
			write_row(REG_AVG_LEN, 32'd1),
			write_row(REG_FEED_GAIN, 32'd65535),
			write_row(REG_FEEDBACK_GAIN, 32'd0),
			typed_row(16'h8000, 24'h800000, 24'hFF9B80, 24'h800000),
			sample_row(16'h7FFF),
			sample_row(16'hFFFF),
			sample_row(16'h0001),
			// zero length acts as one
			write_row(REG_AVG_LEN, 32'd0),
			sample_row(16'h7FFF),
			sample_row(16'h8000),
			// length past the history depth, unity gains that grow to saturation
			write_row(REG_AVG_LEN, 32'd127),
			write_row(REG_FEED_GAIN, 32'd32768),
			write_row(REG_FEEDBACK_GAIN, 32'd32768),
			sample_row(16'h7FFF),
			sample_row(16'h7FFF),
			sample_row(16'h7FFF),
			sample_row(16'h7FFF),
			// unmapped register must not disturb anything
			write_row(REG_SPARE, 32'hFFFF_FFFF),
			write_row(REG_AVG_LEN, 32'd65),
			write_row(REG_FEEDBACK_GAIN, 32'd65535),
			sample_row(16'h8000),
			sample_row(16'h8000),
			sample_row(16'h8000),
			write_row(REG_AVG_LEN, 32'd64),
			write_row(REG_FEED_GAIN, 32'd0),
			write_row(REG_FEEDBACK_GAIN, 32'd0),
			sample_row(16'h5555),
			sample_row(16'hAAAA)
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_register(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i].sample, directed_rows[i].typed,
					directed_rows[i].typed_result);
			end
		end

		// random phases, each with fresh settings and one of four idling modes
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_idle();
			write_register(REG_AVG_LEN, pick_length());
			write_register(REG_FEED_GAIN, pick_gain());
			write_register(REG_FEEDBACK_GAIN, pick_gain());
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 64;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 64;
				end
				default: begin
					send_idle_pct = 18;
					stall_pct     = 18;
				end
			endcase
			if (phase == 4) begin
				hold_trigger++;
			end
			repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, '0);
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
